// ===== hw/rtl/i2cmm_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cmm_pkg
// types and constants shared by the i2c memory access master
// ----------------------------------------------------------------------------
`default_nettype none
package i2cmm_pkg;

  localparam int unsigned HpW = 16;
  localparam int unsigned GpW = 24;
  localparam int unsigned CfgW = 24;
  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CfgHalfPeriod = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgProbeGap = 1'b1;
  localparam logic [HpW-1:0] HpReset = 16'd100;
  localparam logic [GpW-1:0] GpReset = 24'd72000;

  typedef enum logic [1:0] {
    ReqWrite = 2'd0,
    ReqRead  = 2'd1,
    ReqProbe = 2'd2,
    ReqBad   = 2'd3
  } req_e;

  typedef enum logic [4:0] {
    StIdle, StSa, StSb, StSc, StSd, StWbSet, StWbHi, StWbLo, StWaRel, StWaHi,
    StWaLo, StRbRel, StRbHi, StRbLo, StRaSet, StRaHi, StRaLo, StPa, StPb,
    StPc, StGap
  } step_e;

  typedef enum logic [2:0] {
    SgAddr, SgOffHi, SgOffLo, SgData, SgRaddr, SgRead, SgProbe
  } stage_e;

  typedef struct packed {
    logic       start_req;
    logic [1:0] req_type;
    logic [7:0] dev_addr;
    logic [15:0] mem_offset;
    logic       addr_16bit;
    logic [15:0] length;
    logic [15:0] probe_tries;
    logic [7:0] wr_data;
    logic       sda_in;
  } in_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       wr_take;
    logic [7:0] rd_data;
    logic       rd_valid;
    logic       done_res;
    logic       ok;
    logic       busy_res;
  } out_t;

endpackage
`default_nettype wire

// ===== hw/rtl/i2cmm_if.sv =====
// ----------------------------------------------------------------------------
// i2cmm_if
// valid/ready channel carrying one payload
// ----------------------------------------------------------------------------
`default_nettype none
interface i2cmm_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/i2cmm_fifo.sv =====
// ----------------------------------------------------------------------------
// i2cmm_fifo
// two entry queue between tick front end and bus engine
// ----------------------------------------------------------------------------
`default_nettype none
module i2cmm_fifo (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire i2cmm_pkg::in_t  in_data_i,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output i2cmm_pkg::in_t       out_data_o
);
  import i2cmm_pkg::*;

  in_t        mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign in_ready_o  = (cnt_q != 2'd2);
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_data_o  = mem_q[rp_q];
  assign push = in_valid_i && in_ready_o;
  assign pop  = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wp_q] <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q != 2'd3)
    else $error("queue count overflow");
  a_empty_ptr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd0 |-> wp_q == rp_q) else $error("pointers differ while empty");
  a_full_ptr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd2 |-> wp_q == rp_q) else $error("pointers differ while full");
endmodule
`default_nettype wire

// ===== hw/rtl/i2cmm_engine.sv =====
// ----------------------------------------------------------------------------
// i2cmm_engine
// bus sequencer: one tick per beat, result registered with skid buffer
// ----------------------------------------------------------------------------
`default_nettype none
module i2cmm_engine (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic [i2cmm_pkg::HpW-1:0] half_period_i,
  input  wire logic [i2cmm_pkg::GpW-1:0] probe_gap_i,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire i2cmm_pkg::in_t         in_data_i,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output i2cmm_pkg::out_t             out_data_o
);
  import i2cmm_pkg::*;

  step_e  step_q, step_d;
  stage_e stage_q, stage_d;
  logic [15:0] phase_q, phase_d;
  logic [23:0] gap_q, gap_d;
  logic [3:0]  bit_q, bit_d;
  logic [7:0]  shb_q, shb_d;
  logic [15:0] left_q, left_d;
  logic [15:0] tries_q, tries_d;
  logic [1:0]  ltype_q, ltype_d;
  logic [7:0]  laddr_q, laddr_d;
  logic [15:0] loff_q, loff_d;
  logic        la16_q, la16_d;
  logic [15:0] llen_q, llen_d;
  logic        scl_q, scl_d, sda_q, sda_d, ack_q, ack_d;
  out_t        res;

  // output register plus skid slot
  logic  ov_q, sv_q;
  out_t  od_q, sd_q;
  logic  fire;

  assign in_ready_o = !sv_q;
  assign fire = in_valid_i && in_ready_o;
  assign out_valid_o = ov_q;
  assign out_data_o = od_q;

  logic [15:0] hp;
  logic [23:0] gp;
  assign hp = (half_period_i == '0) ? 16'd1 : half_period_i;
  assign gp = (probe_gap_i == '0) ? 24'd1 : probe_gap_i;

  always_comb begin
    logic [15:0] pc;
    logic [3:0]  nb;
    logic [7:0]  ns;
    logic        go;
    step_e       nx;
    step_d = step_q; stage_d = stage_q; phase_d = phase_q; gap_d = gap_q;
    bit_d = bit_q; shb_d = shb_q; left_d = left_q; tries_d = tries_q;
    ltype_d = ltype_q; laddr_d = laddr_q; loff_d = loff_q; la16_d = la16_q;
    llen_d = llen_q; scl_d = scl_q; sda_d = sda_q; ack_d = ack_q;
    res = '0;
    pc = phase_q + 16'd1;
    nb = bit_q; ns = shb_q; go = 1'b0; nx = step_q;
    if (step_q == StIdle) begin
      if (in_data_i.start_req) begin
        ltype_d = in_data_i.req_type;
        laddr_d = in_data_i.dev_addr;
        loff_d = in_data_i.mem_offset;
        la16_d = in_data_i.addr_16bit;
        llen_d = (in_data_i.req_type == ReqProbe) ? in_data_i.probe_tries
                                                  : in_data_i.length;
        stage_d = (in_data_i.req_type == ReqProbe) ? SgProbe : SgAddr;
        left_d = in_data_i.length;
        tries_d = '0;
        ack_d = 1'b0;
        if (in_data_i.req_type == ReqBad) begin
          res.done_res = 1'b1;
        end else if (in_data_i.req_type == ReqRead && in_data_i.length == '0) begin
          res.done_res = 1'b1; res.ok = 1'b1;
        end else begin
          go = 1'b1; nx = StSa;
        end
      end
    end else if (step_q == StGap) begin
      gap_d = gap_q + 24'd1;
      if (gap_d >= gp) begin
        gap_d = '0;
        if (tries_q != 16'hffff) tries_d = tries_q + 16'd1;
        go = 1'b1; nx = StSa;
      end
    end else begin
      phase_d = pc;
      if (pc >= hp) begin
        go = 1'b1;
        unique case (step_q)
          StSa: nx = StSb;
          StSb: nx = StSc;
          StSc: nx = StSd;
          StSd: begin
            ns = (stage_q == SgRaddr) ? (laddr_q | 8'h01) : laddr_q;
            nb = '0; nx = StWbSet;
          end
          StWbSet: nx = StWbHi;
          StWbHi: nx = StWbLo;
          StWbLo: begin
            ns = {shb_q[6:0], 1'b0}; nb = bit_q + 4'd1;
            nx = (nb >= 4'd8) ? StWaRel : StWbSet;
          end
          StWaRel: nx = StWaHi;
          StWaHi: begin ack_d = !in_data_i.sda_in; nx = StWaLo; end
          StWaLo: begin
            if (stage_q == SgProbe || !ack_q) begin
              nx = StPa;
            end else begin
              unique case (stage_q)
                SgAddr: begin
                  nb = '0; nx = StWbSet;
                  if (la16_q) begin stage_d = SgOffHi; ns = loff_q[15:8]; end
                  else begin stage_d = SgOffLo; ns = loff_q[7:0]; end
                end
                SgOffHi: begin stage_d = SgOffLo; ns = loff_q[7:0]; nb = '0; nx = StWbSet; end
                SgOffLo, SgData: begin
                  if (stage_q == SgOffLo && ltype_q != ReqWrite) begin
                    stage_d = SgRaddr; nx = StSa;
                  end else if (left_q == '0) begin
                    nx = StPa;
                  end else begin
                    left_d = left_q - 16'd1; res.wr_take = 1'b1; stage_d = SgData;
                    ns = in_data_i.wr_data; nb = '0; nx = StWbSet;
                  end
                end
                SgRaddr: begin
                  stage_d = SgRead; left_d = llen_q; ns = '0; nb = '0; nx = StRbRel;
                end
                default: nx = StPa;
              endcase
            end
          end
          StRbRel: nx = StRbHi;
          StRbHi: begin
            ns = {shb_q[6:0], in_data_i.sda_in}; nb = bit_q + 4'd1;
            if (nb >= 4'd8) begin res.rd_valid = 1'b1; res.rd_data = ns; end
            nx = StRbLo;
          end
          StRbLo: nx = (bit_q >= 4'd8) ? StRaSet : StRbHi;
          StRaSet: nx = StRaHi;
          StRaHi: nx = StRaLo;
          StRaLo: begin
            left_d = (left_q != '0) ? left_q - 16'd1 : left_q;
            if (left_d == '0) nx = StPa;
            else begin ns = '0; nb = '0; nx = StRbRel; end
          end
          StPa: nx = StPb;
          StPb: nx = StPc;
          StPc: begin
            go = 1'b0;
            phase_d = '0;
            if (stage_q == SgProbe && !ack_q) begin
              if (tries_q >= llen_q) begin
                step_d = StIdle; res.done_res = 1'b1;
              end else begin
                step_d = StGap; gap_d = '0;
              end
            end else begin
              step_d = StIdle; res.done_res = 1'b1; res.ok = ack_q;
            end
          end
          default: begin go = 1'b0; phase_d = '0; step_d = StIdle; res.done_res = 1'b1; end
        endcase
      end
    end
    bit_d = nb; shb_d = ns;
    if (go) begin
      step_d = nx; phase_d = '0;
      unique case (nx)
        StSa, StWaRel, StRbRel, StPc: sda_d = 1'b1;
        StSb, StWbHi, StWaHi, StRbHi, StRaHi, StPb: scl_d = 1'b1;
        StSc, StPa: sda_d = 1'b0;
        StSd, StWbLo, StWaLo, StRbLo, StRaLo: scl_d = 1'b0;
        StWbSet: sda_d = ns[7];
        StRaSet: sda_d = !(left_d > 16'd1);
        default: ;
      endcase
    end
    res.scl_out = scl_d;
    res.sda_out = sda_d;
    res.busy_res = (step_d != StIdle);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= StIdle; stage_q <= SgAddr; phase_q <= '0; gap_q <= '0;
      bit_q <= '0; shb_q <= '0; left_q <= '0; tries_q <= '0;
      ltype_q <= '0; laddr_q <= '0; loff_q <= '0; la16_q <= 1'b0; llen_q <= '0;
      scl_q <= 1'b1; sda_q <= 1'b1; ack_q <= 1'b0;
      ov_q <= 1'b0; sv_q <= 1'b0;
    end else begin
      if (fire) begin
        step_q <= step_d; stage_q <= stage_d; phase_q <= phase_d; gap_q <= gap_d;
        bit_q <= bit_d; shb_q <= shb_d; left_q <= left_d; tries_q <= tries_d;
        ltype_q <= ltype_d; laddr_q <= laddr_d; loff_q <= loff_d; la16_q <= la16_d;
        llen_q <= llen_d; scl_q <= scl_d; sda_q <= sda_d; ack_q <= ack_d;
      end
      if (!ov_q || out_ready_i) begin
        ov_q <= sv_q || fire;
        sv_q <= 1'b0;
      end else if (fire) begin
        sv_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!ov_q || out_ready_i) begin
      od_q <= sv_q ? sd_q : res;
    end else if (fire) begin
      sd_q <= res;
    end
  end

  a_skid: assert property (@(posedge clk_i) disable iff (!rst_ni) sv_q |-> ov_q)
    else $error("skid full with empty output");
  a_bits: assert property (@(posedge clk_i) disable iff (!rst_ni) bit_q <= 4'd8)
    else $error("bit count out of range");
  a_idle_lines: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q == StIdle && $past(step_q) != StIdle && $past(fire) |-> scl_q && sda_q)
    else $error("bus not released at idle");
endmodule
`default_nettype wire

// ===== hw/rtl/i2c_master_memory_access_top.sv =====
// ----------------------------------------------------------------------------
// i2c_master_memory_access_top
// i2c memory read/write master, one input beat per bus tick
// ----------------------------------------------------------------------------
// Each input beat is one tick carrying a request and the sampled SDA level;
// each produces one result beat with SCL/SDA levels and status. A two entry
// queue feeds the bus sequencer, which takes one beat per cycle while its skid
// slot is free, so the block keeps one beat per clock; results are registered.
`default_nettype none
module i2c_master_memory_access_top (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [i2cmm_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [i2cmm_pkg::CfgW-1:0]    cfg_wdata_i,
  i2cmm_if.sink                  in_ch,
  i2cmm_if.source                out_ch
);
  import i2cmm_pkg::*;

  logic [HpW-1:0] hp_q;
  logic [GpW-1:0] gp_q;
  logic  q_valid, q_ready;
  in_t   q_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hp_q <= HpReset;
      gp_q <= GpReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgHalfPeriod: hp_q <= cfg_wdata_i[HpW-1:0];
        CfgProbeGap:   gp_q <= cfg_wdata_i[GpW-1:0];
        default: ;
      endcase
    end
  end

  i2cmm_fifo u_fifo (
    .clk_i, .rst_ni,
    .in_valid_i(in_ch.valid), .in_ready_o(in_ch.ready), .in_data_i(in_ch.data),
    .out_valid_o(q_valid), .out_ready_i(q_ready), .out_data_o(q_data)
  );

  i2cmm_engine u_engine (
    .clk_i, .rst_ni,
    .half_period_i(hp_q), .probe_gap_i(gp_q),
    .in_valid_i(q_valid), .in_ready_o(q_ready), .in_data_i(q_data),
    .out_valid_o(out_ch.valid), .out_ready_i(out_ch.ready), .out_data_o(out_ch.data)
  );
endmodule
`default_nettype wire
